@@ rtl/core/seed_sha256_truncated_top_defines.svh @@
// Assertion macros shared by the checker.
`ifndef SEED_SHA256_TRUNCATED_TOP_DEFINES_SVH
`define SEED_SHA256_TRUNCATED_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define SST_CHK_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sst check failed");

// Next-cycle implication, masked during reset.
`define SST_CHK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sst check failed");

// Next-cycle implication, live through reset.
`define SST_CHK_NEXT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("sst check failed");

`endif

@@ rtl/core/sst_pkg.sv @@
package sst_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumWin    = 16;

  localparam logic [31:0] MsgPad = 32'h80000000;
  localparam logic [31:0] MsgLen = 32'h00000040;

  localparam logic [31:0] INIT_H [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Working words a..h in v[0]..v[7]; schedule window w[0] is the current word.
  typedef struct packed {
    logic [NumWin-1:0][31:0] w;
    logic [7:0][31:0]        v;
  } sst_state_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ rtl/core/sst_round.sv @@
// One compression round plus one schedule step, registered.
module sst_round import sst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en_i,
  input  logic       valid_i,
  input  sst_state_t st_i,
  input  logic [31:0] k_i,
  output logic       valid_o,
  output sst_state_t st_o
);

  logic       valid_r;
  sst_state_t st_r;
  sst_state_t st_nxt;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  always_comb begin
    t1 = st_i.v[7] + bsig1(st_i.v[4])
       + ((st_i.v[4] & st_i.v[5]) ^ (~st_i.v[4] & st_i.v[6]))
       + k_i + st_i.w[0];
    t2 = bsig0(st_i.v[0])
       + ((st_i.v[0] & st_i.v[1]) ^ (st_i.v[0] & st_i.v[2]) ^ (st_i.v[1] & st_i.v[2]));
    w_new = ssig1(st_i.w[14]) + st_i.w[9] + ssig0(st_i.w[1]) + st_i.w[0];
    st_nxt.v = {st_i.v[6:4], st_i.v[3] + t1, st_i.v[2:0], t1 + t2};
    st_nxt.w = {w_new, st_i.w[NumWin-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en_i) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      st_r <= st_nxt;
    end
  end

  assign valid_o = valid_r;
  assign st_o    = st_r;

endmodule

@@ rtl/core/seed_sha256_truncated_top.sv @@
// Truncated SHA-256 of a 64-bit seed: the eight seed bytes, little-endian, are
// hashed as one padded block and the first eight digest bytes come back as a
// little-endian 64-bit word. Fully pipelined: one word accepted per cycle while
// in_ready is high (one register stage per compression round, 64 of them,
// then the final add and byte swap in the output register). The
// whole pipe advances together, so a stall on the result side holds every
// stage and in_ready drops only while a result waits and out_ready is low.
module seed_sha256_truncated_top import sst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_prefix
);

  // Pipe moves whenever the output register is free or being drained.
  logic en;

  logic       stg_valid [0:NumRounds];
  sst_state_t stg_st    [0:NumRounds];

  logic        out_valid_r;
  logic [63:0] out_digest_prefix_r;
  logic [31:0] d0;
  logic [31:0] d1;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Padded message block and initial hash values feed round 0.
  always_comb begin
    stg_valid[0] = in_valid;
    stg_st[0].w  = '0;
    stg_st[0].w[0]  = swap32(in_seed[31:0]);
    stg_st[0].w[1]  = swap32(in_seed[63:32]);
    stg_st[0].w[2]  = MsgPad;
    stg_st[0].w[15] = MsgLen;
    for (int j = 0; j < 8; j++) begin
      stg_st[0].v[j] = INIT_H[j];
    end
  end

  // One round per stage; the schedule window shifts along with the data.
  for (genvar i = 0; i < NumRounds; i++) begin : g_round
    sst_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en_i    (en),
      .valid_i (stg_valid[i]),
      .st_i    (stg_st[i]),
      .k_i     (ROUND_K[i]),
      .valid_o (stg_valid[i+1]),
      .st_o    (stg_st[i+1])
    );
  end

  // Only a and b get the initial values added back.
  assign d0 = stg_st[NumRounds].v[0] + INIT_H[0];
  assign d1 = stg_st[NumRounds].v[1] + INIT_H[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg_valid[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_digest_prefix_r <= {swap32(d1), swap32(d0)};
    end
  end

  assign out_valid         = out_valid_r;
  assign out_digest_prefix = out_digest_prefix_r;

endmodule

@@ rtl/core/sst_chk.sv @@
`include "seed_sha256_truncated_top_defines.svh"

// Port-level checks for the seed hash pipe.
module sst_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [63:0] in_seed,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_prefix
);

  // Offered seed held until taken.
  `SST_CHK_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_seed))
  // Result held until taken.
  `SST_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SST_CHK_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_digest_prefix))
  // Pipe never stalls input while nothing waits at the output.
  `SST_CHK_NOW(a_ready_free, !out_valid || out_ready, in_ready)
  // Reset empties the pipe.
  `SST_CHK_NEXT_RST(a_rst_empty, !rst_n, !out_valid)

endmodule

bind seed_sha256_truncated_top sst_chk u_sst_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_seed           (in_seed),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_digest_prefix (out_digest_prefix)
);
